/* rtl/itp_pkg.sv */
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, token codes and precedence helpers for the infix-to-postfix
// converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int KIND_W          = 4;
  localparam int PREC_W          = 7;

  localparam logic [PREC_W-1:0] PREC_OPERAND = PREC_W'(100);
  localparam logic [PREC_W-1:0] PREC_FUNC    = PREC_W'(4);
  localparam logic [PREC_W-1:0] PREC_POWER   = PREC_W'(3);
  localparam logic [PREC_W-1:0] PREC_PRODUCT = PREC_W'(2);
  localparam logic [PREC_W-1:0] PREC_SUM     = PREC_W'(1);
  localparam logic [PREC_W-1:0] PREC_NONE    = PREC_W'(0);

  typedef enum logic [KIND_W-1:0] {
    K_NUM   = 4'd0,
    K_X     = 4'd1,
    K_OPEN  = 4'd2,
    K_CLOSE = 4'd3,
    K_ADD   = 4'd4,
    K_SUB   = 4'd5,
    K_MUL   = 4'd6,
    K_DIV   = 4'd7,
    K_POW   = 4'd8,
    K_NEG   = 4'd9,
    K_ABS   = 4'd10,
    K_SQRT  = 4'd11,
    K_SIN   = 4'd12,
    K_COS   = 4'd13,
    K_TAN   = 4'd14,
    K_END   = 4'd15
  } kind_t;

  // Request from the sequencer to the output buffer.
  typedef struct packed {
    logic  emit;
    logic  flush;
    logic  ovf;
    kind_t kind;
  } emit_req_t;

  function automatic logic [PREC_W-1:0] prec_of(kind_t k);
    logic [PREC_W-1:0] p;
    case (k)
      K_NUM, K_X:                         p = PREC_OPERAND;
      K_ADD, K_SUB:                       p = PREC_SUM;
      K_MUL, K_DIV:                       p = PREC_PRODUCT;
      K_POW, K_NEG:                       p = PREC_POWER;
      K_ABS, K_SQRT, K_SIN, K_COS, K_TAN: p = PREC_FUNC;
      default:                            p = PREC_NONE;
    endcase
    return p;
  endfunction

  function automatic logic left_assoc(kind_t k);
    return k inside {[K_ADD:K_DIV]};
  endfunction

endpackage

/* rtl/itp_ram.sv */
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itp_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/itp_emit_buf.sv */
// ----------------------------------------------------------------------------
// itp_emit_buf
// Output stage: one hold slot plus the output register. A word waits in the
// hold slot until the next word or the end of the item tells whether it is
// the last one of the run.
// ----------------------------------------------------------------------------
module itp_emit_buf import itp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  emit_req_t              req,
  input  logic [VALUE_WIDTH-1:0] req_value,
  output logic                   buf_ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [KIND_W-1:0]      out_kind,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic                   last_of_run,
  output logic                   overflow_error
);

  logic                   hold_valid;
  kind_t                  hold_kind;
  logic [VALUE_WIDTH-1:0] hold_value;
  logic                   hold_ovf;
  logic                   out_free;
  logic                   move;
  logic                   load;

  assign out_free  = !out_valid || !out_stall;
  assign buf_ready = !hold_valid || out_free;
  assign move      = hold_valid && out_free && (req.emit || req.flush);
  assign load      = req.emit && buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        hold_valid <= 1'b1;
      end else if (move) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_kind       <= hold_kind;
      out_value      <= hold_value;
      overflow_error <= hold_ovf;
      last_of_run    <= req.flush;
    end
    if (load) begin
      hold_kind  <= req.kind;
      hold_value <= req_value;
      hold_ovf   <= req.ovf;
    end
  end

endmodule

/* rtl/itp_seq.sv */
// ----------------------------------------------------------------------------
// itp_seq
// Token sequencer: owns the stack count and runs the precedence compare on
// each top; walks the RAM stack one entry per cycle while buf_ready is high.
// ----------------------------------------------------------------------------
module itp_seq import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int CW = $clog2(STACK_DEPTH + 1),
  localparam int EW = KIND_W + VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  kind_t                  in_kind,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output logic [EW-1:0]          ram_wdata,
  output logic [AW-1:0]          ram_raddr,
  input  logic [EW-1:0]          ram_rdata,
  output emit_req_t              req,
  output logic [VALUE_WIDTH-1:0] req_value,
  input  logic                   buf_ready
);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_EVAL = 5'b00100,
    S_PUSH = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                 state, state_next;
  logic [CW-1:0]          cnt, cnt_next;
  kind_t                  kind, kind_next;
  logic [VALUE_WIDTH-1:0] value, value_next;

  kind_t                  top_kind;
  logic [VALUE_WIDTH-1:0] top_value;
  logic [PREC_W-1:0]      p, q;
  logic [CW-1:0]          cnt_m1, cnt_m2;
  logic                   empty;
  logic                   stop;
  logic                   pop;
  logic                   need_emit;

  assign top_kind  = kind_t'(ram_rdata[EW-1 -: KIND_W]);
  assign top_value = ram_rdata[VALUE_WIDTH-1:0];
  assign p         = prec_of(kind);
  assign q         = prec_of(top_kind);
  assign cnt_m1    = cnt - CW'(1);
  assign cnt_m2    = cnt - CW'(2);
  assign empty     = (cnt == '0);
  assign need_emit = (top_kind != K_OPEN);
  assign in_stall  = (state != S_IDLE);

  // Keep the top in the read register unless it is popped this cycle.
  assign ram_raddr = pop ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];

  always_comb begin
    case (kind)
      K_CLOSE: stop = empty || (top_kind == K_OPEN);
      K_END:   stop = empty;
      default: stop = empty || !((q > p) || ((q == p) && left_assoc(kind)));
    endcase
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    kind_next  = kind;
    value_next = value;
    ram_we     = 1'b0;
    ram_waddr  = cnt[AW-1:0];
    ram_wdata  = {kind, value};
    req        = '0;
    req.kind   = top_kind;
    req_value  = top_value;
    pop        = 1'b0;
    case (state)
      S_INIT: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = {K_OPEN, {VALUE_WIDTH{1'b0}}};
        cnt_next   = CW'(1);
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_next  = in_kind;
          value_next = (in_kind == K_NUM) ? in_value : '0;
          if (in_kind inside {K_NUM, K_X, K_OPEN}) begin
            state_next = S_PUSH;
          end else begin
            state_next = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (stop) begin
          case (kind)
            K_CLOSE: begin
              // drop the matching open
              if (!empty) begin
                cnt_next = cnt_m1;
              end
              state_next = S_FIN;
            end
            K_END: begin
              // re-seed the open marker
              ram_we     = 1'b1;
              ram_waddr  = '0;
              ram_wdata  = {K_OPEN, {VALUE_WIDTH{1'b0}}};
              cnt_next   = CW'(1);
              state_next = S_FIN;
            end
            default: state_next = S_PUSH;
          endcase
        end else if (!need_emit || buf_ready) begin
          pop      = 1'b1;
          cnt_next = cnt_m1;
          req.emit = need_emit;
        end
      end
      S_PUSH: begin
        if (cnt < CW'(STACK_DEPTH)) begin
          ram_we     = 1'b1;
          cnt_next   = cnt + CW'(1);
          state_next = S_FIN;
        end else if (buf_ready) begin
          // stack full: report the dropped token
          req.emit   = 1'b1;
          req.ovf    = 1'b1;
          req.kind   = kind;
          req_value  = value;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        req.flush = 1'b1;
        if (buf_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    kind  <= kind_next;
    value <= value_next;
  end

endmodule

/* rtl/infix_to_postfix_converter.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from classified infix tokens to postfix words.
// ----------------------------------------------------------------------------
// One token word is taken at a time; in_stall stays high while it is
// processed. A pushed token (num, x, open) goes through the push and finish
// states. A close, an operator or an end goes through the evaluate state,
// which pops one stack entry per cycle while the output buffer is ready, and
// then the finish state; an operator goes through the push state in between.
// The operator stack is a RAM with a registered read port. Postfix words
// leave through a hold slot and an output register, so the next token is
// accepted while a result word still waits; a stalled output holds the
// sequencer only when both are full. The last word of each token carries
// last_of_run. After reset the block seeds the open marker before any token.
module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [KIND_W-1:0]      func,
  input  logic [VALUE_WIDTH-1:0] literal_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [KIND_W-1:0]      out_kind,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic                   last_of_run,
  output logic                   overflow_error
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int EW = KIND_W + VALUE_WIDTH;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;
  emit_req_t              req;
  logic [VALUE_WIDTH-1:0] req_value;
  logic                   buf_ready;

  itp_seq #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (kind_t'(func)),
    .in_value  (literal_value),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .req       (req),
    .req_value (req_value),
    .buf_ready (buf_ready)
  );

  itp_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  itp_emit_buf #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_emit (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .req_value      (req_value),
    .buf_ready      (buf_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .last_of_run    (last_of_run),
    .overflow_error (overflow_error)
  );

endmodule
